/* hw/rtl/slip_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package slip_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned ENTRY_W = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_SORTED = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_POP    = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INS,
    OP_POP
  } cell_op_t;

  typedef struct packed {
    cell_op_t                   op;
    logic                       append;
    logic signed [DATA_W-1:0]   value;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/slip_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none

interface slip_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface slip_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] popped_value;
  logic               pop_valid;
  logic [1:0]         status;
  logic [4:0]         entry_count;

  modport source (output valid, output popped_value, output pop_valid, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input popped_value, input pop_valid, input status,
                  input entry_count, output ready);
endinterface

`default_nettype wire

/* hw/rtl/slip_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module slip_cell (
  input  wire logic                              clk,
  input  wire slip_pkg::cell_ctl_t               ctl,
  input  wire logic                              is_head,
  input  wire logic                              valid,
  input  wire logic signed [slip_pkg::DATA_W-1:0] left_data,
  input  wire logic signed [slip_pkg::DATA_W-1:0] right_data,
  input  wire logic                              before_in,
  output logic                                   before_out,
  output logic signed [slip_pkg::DATA_W-1:0]     data
);
  import slip_pkg::*;

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;
  logic                     hit;

  always_comb begin
    hit        = is_head ? (data_r <= ctl.value) : (data_r < ctl.value);
    before_out = before_in && valid && (ctl.append || hit);
  end

  always_comb begin
    unique case (ctl.op)
      OP_INS: begin
        if (!before_in) begin
          data_nxt = left_data;
        end else if (!before_out) begin
          data_nxt = ctl.value;
        end else begin
          data_nxt = data_r;
        end
      end
      OP_POP:  data_nxt = right_data;
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

/* hw/rtl/sorted_list_insert_append_pop.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Fields                                          Transfer
// in_ch     in   kind[1:0], value[31:0] signed                   valid & ready
// out_ch    out  popped_value, pop_valid, status, entry_count    valid & ready
//
// One item per cycle while out_ch takes each result: every slot cell decides its
// insert position and shifts in the same cycle, and the transfer registers the result.
// The before-position flag ripples through the row of DEPTH cells.
// Reset clears the entry count and the result valid flag; slot data is not reset.
// A stalled result holds the input side only while it is not taken.

module sorted_list_insert_append_pop (
  input  wire logic   clk,
  input  wire logic   rst_n,
  slip_in_if.sink     in_ch,
  slip_out_if.source  out_ch
);
  import slip_pkg::*;

  logic                     accept;
  logic                     full;
  logic                     empty;
  kind_t                    kind;
  cell_ctl_t                ctl;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic [DEPTH-1:0]         valid_vec;
  logic [DEPTH-1:0]         hold_vec;
  logic signed [DATA_W-1:0] slot_data [DEPTH];

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] popped_r;
  logic signed [DATA_W-1:0] popped_nxt;
  logic                     pop_valid_r;
  logic                     pop_valid_nxt;
  status_t                  status_r;
  status_t                  status_nxt;
  logic [ENTRY_W-1:0]       entry_r;

  assign kind   = kind_t'(in_ch.kind);
  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    ctl.value     = in_ch.value;
    ctl.append    = (kind == KIND_APPEND);
    ctl.op        = OP_HOLD;
    count_nxt     = count_r;
    popped_nxt    = '0;
    pop_valid_nxt = 1'b0;
    status_nxt    = STAT_OK;
    unique case (kind)
      KIND_SORTED, KIND_APPEND: begin
        if (full) begin
          status_nxt = STAT_FULL;
        end else begin
          ctl.op    = accept ? OP_INS : OP_HOLD;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      KIND_POP: begin
        if (empty) begin
          status_nxt = STAT_EMPTY;
        end else begin
          ctl.op        = accept ? OP_POP : OP_HOLD;
          count_nxt     = count_r - CNT_W'(1);
          popped_nxt    = slot_data[0];
          pop_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign valid_vec[i] = (count_r > CNT_W'(i));

    slip_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .is_head    ((i == 0) ? 1'b1 : 1'b0),
      .valid      (valid_vec[i]),
      .left_data  ((i == 0) ? in_ch.value : slot_data[(i == 0) ? 0 : i - 1]),
      .right_data ((i == DEPTH - 1) ? slot_data[i] : slot_data[(i == DEPTH - 1) ? i : i + 1]),
      .before_in  ((i == 0) ? 1'b1 : hold_vec[(i == 0) ? 0 : i - 1]),
      .before_out (hold_vec[i]),
      .data       (slot_data[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      popped_r    <= popped_nxt;
      pop_valid_r <= pop_valid_nxt;
      status_r    <= status_nxt;
      entry_r     <= ENTRY_W'(count_nxt);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.popped_value = popped_r;
  assign out_ch.pop_valid    = pop_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.entry_count  = entry_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    accept && kind == KIND_POP && !empty |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("pop did not remove one entry");

  a_ins_inc: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (kind == KIND_SORTED || kind == KIND_APPEND) && !full
    |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not add one entry");

  a_entry_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> entry_r == ENTRY_W'(count_r))
    else $error("reported entry count differs from held count");

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import slip_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 80;

  typedef struct {
    kind_t              kind;
    logic signed [31:0] value;
    bit                 drain;
  } list_op_t;

  typedef struct {
    logic signed [31:0] popped;
    logic               valid;
    status_t            status;
    logic [4:0]         count;
  } pop_result_t;

  logic clk;
  logic rst_n;

  slip_in_if  in_ch ();
  slip_out_if out_ch ();

  sorted_list_insert_append_pop dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  list_op_t           ops_pending[$];
  pop_result_t        results_due[$];
  logic signed [31:0] list_q[$];

  int errors    = 0;
  int idle_cyc  = 0;
  int taken_cnt = 0;
  int send_gap  = 0;
  int recv_gap  = 0;
  bit send_burst = 0;
  bit recv_burst = 0;
  bit in_took   = 0;
  bit out_took  = 0;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int gap_len(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3, 4: return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic pop_result_t step_list(kind_t k, logic signed [31:0] v);
    pop_result_t r;
    int pos;
    r.popped = '0;
    r.valid  = 1'b0;
    r.status = STAT_OK;
    case (k)
      KIND_SORTED, KIND_APPEND: begin
        if (list_q.size() >= DEPTH) begin
          r.status = STAT_FULL;
        end else if (k == KIND_APPEND) begin
          list_q.push_back(v);
        end else if (list_q.size() == 0 || v < list_q[0]) begin
          list_q.push_front(v);
        end else begin
          pos = 1;
          while (pos < list_q.size() && list_q[pos] < v) pos++;
          list_q.insert(pos, v);
        end
      end
      KIND_POP: begin
        if (list_q.size() == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.popped = list_q.pop_front();
          r.valid  = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = 5'(list_q.size());
    return r;
  endfunction

  task automatic note_mismatch(string field, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("%0t: %s mismatch: got %0h, want %0h", $realtime, field, got, want);
  endtask

  task automatic add_op(kind_t k, logic signed [31:0] v, bit drain);
    list_op_t op;
    op.kind  = k;
    op.value = v;
    op.drain = drain;
    ops_pending.push_back(op);
  endtask

  // sample transfers, check results, predict
  always @(posedge clk) begin
    if (rst_n) begin
      in_took  = in_ch.valid && in_ch.ready;
      out_took = out_ch.valid && out_ch.ready;
      if (out_took) begin
        taken_cnt++;
        if (results_due.size() == 0) begin
          note_mismatch("unexpected transfer", {30'd0, out_ch.status}, '0);
        end else begin
          pop_result_t want;
          want = results_due.pop_front();
          if (out_ch.popped_value !== want.popped)
            note_mismatch("popped_value", out_ch.popped_value, want.popped);
          if (out_ch.pop_valid !== want.valid)
            note_mismatch("pop_valid", 32'(out_ch.pop_valid), 32'(want.valid));
          if (out_ch.status !== want.status)
            note_mismatch("status", 32'(out_ch.status), 32'(want.status));
          if (out_ch.entry_count !== want.count)
            note_mismatch("entry_count", 32'(out_ch.entry_count), 32'(want.count));
        end
      end
      if (in_took)
        results_due.push_back(step_list(kind_t'(in_ch.kind), in_ch.value));
      if (in_took || out_took) idle_cyc = 0;
      else idle_cyc++;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("** sorted_list_insert_append_pop: FAILED **");
        $finish;
      end
    end
  end

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (in_took) begin
        in_took = 0;
        if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
        send_gap = gap_len(send_burst);
      end
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (ops_pending.size() != 0 &&
                   !(ops_pending[0].drain && results_due.size() != 0)) begin
        list_op_t op;
        op = ops_pending.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.kind  <= op.kind;
        in_ch.value <= op.value;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_took) begin
        out_took = 0;
        if ($urandom_range(0, 63) == 0) recv_burst = !recv_burst;
        if (taken_cnt == 300 || taken_cnt == 900) recv_gap = LONG_HOLD;
        else recv_gap = gap_len(recv_burst);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int total;
    int block_len;
    int p_ins;
    int r;
    kind_t k;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_NONE;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;

    add_op(KIND_POP,    32'sd0, 1'b0);
    add_op(KIND_NONE,   32'sh7FFF_FFFF, 1'b0);
    add_op(KIND_SORTED, 32'sd0, 1'b0);
    add_op(KIND_SORTED, 32'sh8000_0000, 1'b0);
    add_op(KIND_SORTED, 32'sh8000_0000, 1'b0);
    add_op(KIND_SORTED, 32'sh7FFF_FFFF, 1'b0);
    add_op(KIND_APPEND, -32'sd7, 1'b0);
    add_op(KIND_SORTED, 32'sd100, 1'b0);
    add_op(KIND_APPEND, 32'sh7FFF_FFFF, 1'b0);
    add_op(KIND_NONE,   -32'sd1, 1'b0);
    for (int i = 0; i < 9; i++)
      add_op(KIND_APPEND, (i % 2) ? 32'sh5555_5555 : 32'shAAAA_AAAA, 1'b0);
    add_op(KIND_SORTED, -32'sd1, 1'b0);
    add_op(KIND_APPEND, 32'sd1, 1'b0);
    add_op(KIND_NONE,   32'sd0, 1'b0);

    total = 0;
    while (total < 1200) begin
      block_len = $urandom_range(20, 80);
      case ($urandom_range(0, 3))
        0:       p_ins = 15;
        1:       p_ins = 50;
        2:       p_ins = 85;
        default: p_ins = 60;
      endcase
      for (int i = 0; i < block_len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 3) k = KIND_NONE;
        else if (r < 3 + p_ins) k = ($urandom_range(0, 9) < 7) ? KIND_SORTED : KIND_APPEND;
        else k = KIND_POP;
        add_op(k, pick_value(), i == 0);
      end
      total += block_len;
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (ops_pending.size() != 0 || in_ch.valid) @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("** sorted_list_insert_append_pop: PASSED **");
    end else begin
      $display("** sorted_list_insert_append_pop: FAILED **");
    end
    $finish;
  end

endmodule
